[hdl/mrrva_pkg.sv]
// ----------------------------------------------------------------------------
// mrrva_pkg: shared types and constants for the MPE voice allocator
// Event kinds, the input word layout and the output word layout.
// ----------------------------------------------------------------------------
`default_nettype none
package mrrva_pkg;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_BEND     = 3'd2;
  localparam logic [2:0] KIND_OTHER    = 3'd3;
  localparam logic [2:0] KIND_POLY     = 3'd4;

  localparam logic [1:0] OUT_NOTE_ON  = 2'd0;
  localparam logic [1:0] OUT_NOTE_OFF = 2'd1;
  localparam logic [1:0] OUT_BEND     = 2'd2;
  localparam logic [1:0] OUT_OTHER    = 2'd3;

  localparam int NOTE_COUNT = 128;

  typedef struct packed {
    logic [15:0] sample_pos;
    logic [3:0]  new_poly;
    logic [3:0]  status_type;
    logic [13:0] bend;
    logic [6:0]  velocity;
    logic [6:0]  note;
    logic [2:0]  kind;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_time;
    logic [3:0]  out_status;
    logic [13:0] out_bend;
    logic [6:0]  out_velocity;
    logic [6:0]  out_note;
    logic [4:0]  out_channel;
    logic [1:0]  kind_out;
  } out_word_t;

endpackage
`default_nettype wire

[hdl/mrrva_vel_mem.sv]
// ----------------------------------------------------------------------------
// mrrva_vel_mem: held-velocity table
// 128 x 7 synchronous RAM, one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mrrva_vel_mem (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [6:0] addr,
  input  wire logic [6:0] wdata,
  output logic      [6:0] rdata
);
  logic [6:0] mem [mrrva_pkg::NOTE_COUNT];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/mpe_round_robin_voice_allocator_core.sv]
// A mono release holds its note-off until the 128-entry velocity RAM scan ends.
// One word at a time: the next input is taken only after the last result has left;
//   bend emits one word per voice, and a mono selection clears the velocity RAM.
// Reset: clears all voices and runs a clear of all 128 velocity RAM entries; no
//   input is taken until that clear ends.
// ----------------------------------------------------------------------------
// mpe_round_robin_voice_allocator_core: MPE round-robin voice allocator
// Assigns per-note channels with voice stealing and a mono retrigger table.
// ----------------------------------------------------------------------------
`default_nettype none
module mpe_round_robin_voice_allocator_core #(
  parameter int VOICES = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // kind, note, velocity, bend, status_type, new_poly, sample_pos (pad to 56)
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // kind_out, out_channel, out_note, out_velocity, out_bend, out_status,
  // out_time (pad to 56)
  output logic      [55:0] m_tdata,
  output logic             m_tlast
);
  localparam int VW = $clog2(VOICES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ON = 4'd2,
    S_OFF = 4'd3, S_BEND = 4'd4, S_POLY = 4'd5, S_SCAN = 4'd6,
    S_SCANW = 4'd7, S_EMIT = 4'd8, S_ON2 = 4'd9, S_ON3 = 4'd10;

  logic [3:0] state;
  mrrva_pkg::in_word_t iw;
  // voice notes: bit7 set = free
  logic [7:0] vnote [VOICES];
  logic [VW-1:0] rpos, inuse, k, vsel;
  logic          rpos_none;
  logic [7:0]    cur;
  logic [7:0]    scan;
  logic          ofull, olast;
  mrrva_pkg::out_word_t ow;
  logic [6:0]    vaddr, vwdata, vrdata;
  logic          vwe;
  logic          vdone;
  logic [3:0]    poly_req;

  // queued emissions inside a note-on: up to three words
  logic [1:0]    step;

  mrrva_vel_mem u_mem (.clk, .we(vwe), .addr(vaddr), .wdata(vwdata), .rdata(vrdata));

  assign s_tready = (state == S_IDLE) && !ofull;
  assign m_tvalid = ofull;
  assign m_tdata  = {1'b0, ow};
  assign m_tlast  = olast;

  logic [VW-1:0] nxt, prv, base;
  logic          later;
  always_comb begin
    nxt = (rpos_none || rpos + 1'b1 >= inuse) ? '0 : rpos + 1'b1;
    // no voice chosen walks back from the top voice in use
    base = rpos_none ? inuse - 1'b1 : rpos;
    prv = (k > base) ? base + inuse - k : base - k;
    poly_req = (iw.new_poly == 4'd0) ? 4'd1 :
               ({1'b0, iw.new_poly} > 5'(VOICES)) ? 4'(VOICES) : iw.new_poly;
  end

  // any active voice above the one being released by a polyphony change
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < VOICES; i++)
      if (VW'(i) > VW'(poly_req) + k && VW'(i) < inuse && !vnote[i][7]) later = 1'b1;
  end

  function automatic mrrva_pkg::out_word_t mk(logic [1:0] kd, logic [VW-1:0] v,
      logic [6:0] n, logic [6:0] vl, logic [13:0] b, logic [3:0] st, logic [15:0] t);
    mrrva_pkg::out_word_t o;
    o.kind_out = kd; o.out_channel = 5'(v) + 5'd2; o.out_note = n;
    o.out_velocity = vl; o.out_bend = b; o.out_status = st; o.out_time = t;
    return o;
  endfunction

  wire ofree = !ofull || m_tready;

  always_ff @(posedge clk) begin
    vwe <= 1'b0;
    if (ofull && m_tready) ofull <= 1'b0;
    if (rst) begin
      state <= S_CLEAR; ofull <= 1'b0; olast <= 1'b0;
      for (int i = 0; i < VOICES; i++) vnote[i] <= 8'hFF;
      rpos <= '0; rpos_none <= 1'b1; cur <= 8'hFF; inuse <= VW'(VOICES);
      scan <= '0; vaddr <= '0; vwdata <= '0; vwe <= 1'b1; k <= '0; step <= '0;
      vsel <= '0; vdone <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (scan[6:0] == 7'd127) state <= S_IDLE;
          else begin
            scan <= scan + 8'd1; vaddr <= scan[6:0] + 7'd1; vwdata <= '0; vwe <= 1'b1;
          end
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          iw <= s_tdata[$bits(iw)-1:0]; k <= '0; step <= '0;
          case (s_tdata[2:0])
            mrrva_pkg::KIND_NOTE_ON:
              state <= (s_tdata[16:10] != 7'd0) ? S_ON : S_OFF;
            mrrva_pkg::KIND_NOTE_OFF: state <= S_OFF;
            mrrva_pkg::KIND_BEND:     state <= S_BEND;
            mrrva_pkg::KIND_OTHER: begin
              ow <= '{kind_out: mrrva_pkg::OUT_OTHER, out_channel: 5'd1,
                      out_note: s_tdata[9:3], out_velocity: s_tdata[16:10],
                      out_bend: '0, out_status: s_tdata[34:31],
                      out_time: s_tdata[54:39]};
              ofull <= 1'b1; olast <= 1'b1;
            end
            mrrva_pkg::KIND_POLY: state <= S_POLY;
            default: ;
          endcase
        end
        S_ON: begin
          // round-robin search: one voice per cycle
          if (k == inuse) begin
            // steal
            rpos <= nxt; rpos_none <= 1'b0; vsel <= nxt; state <= S_ON2; step <= 2'd0;
          end else begin
            rpos <= nxt; rpos_none <= 1'b0; k <= k + 1'b1;
            if (vnote[nxt][7]) begin vsel <= nxt; state <= S_ON2; step <= 2'd1; end
          end
        end
        S_ON2: if (ofree) begin
          case (step)
            2'd0: begin
              ow <= mk(mrrva_pkg::OUT_NOTE_OFF, vsel, vnote[vsel][6:0], '0, '0, '0,
                       iw.sample_pos);
              ofull <= 1'b1; olast <= 1'b0; step <= 2'd1;
            end
            2'd1: begin
              if (inuse == VW'(1) && !cur[7]) begin
                ow <= mk(mrrva_pkg::OUT_NOTE_OFF, vsel, cur[6:0], '0, '0, '0,
                         iw.sample_pos);
                ofull <= 1'b1; olast <= 1'b0;
              end
              step <= 2'd2;
            end
            default: begin
              ow <= mk(mrrva_pkg::OUT_NOTE_ON, vsel, iw.note, iw.velocity, '0, '0,
                       iw.sample_pos);
              ofull <= 1'b1; olast <= 1'b1;
              cur <= {1'b0, iw.note}; vnote[vsel] <= {1'b0, iw.note};
              vaddr <= iw.note; vwdata <= iw.velocity; vwe <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_OFF: begin
          // backward search from the last used voice
          if (k == inuse) begin
            vaddr <= iw.note; vwdata <= '0; vwe <= 1'b1;
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
            if (!vnote[prv][7] && vnote[prv][6:0] == iw.note) begin
              vaddr <= iw.note; vwdata <= '0; vwe <= 1'b1;
              vsel <= prv; state <= S_ON3;
            end
          end
        end
        S_ON3: if (ofree) begin
          vnote[vsel] <= 8'hFF; cur <= 8'hFF;
          if (inuse != VW'(1)) begin
            ow <= mk(mrrva_pkg::OUT_NOTE_OFF, vsel, iw.note, iw.velocity, '0, '0,
                     iw.sample_pos);
            ofull <= 1'b1; olast <= 1'b1; state <= S_IDLE;
          end else begin
            // mono: the note-off waits until the scan knows if a retrigger follows
            scan <= '0; vaddr <= '0; state <= S_SCANW;
          end
        end
        S_SCANW: state <= S_SCAN;   // read latency
        S_SCAN: begin
          if (vrdata != 7'd0 || scan[6:0] == 7'd127) begin
            state <= S_EMIT;
          end else begin
            scan <= scan + 8'd1; vaddr <= scan[6:0] + 7'd1; state <= S_SCANW;
          end
        end
        S_EMIT: if (ofree) begin
          // vrdata holds the held velocity of the lowest held note, zero if none
          if (step == 2'd0) begin
            ow <= mk(mrrva_pkg::OUT_NOTE_OFF, vsel, iw.note, iw.velocity, '0, '0,
                     iw.sample_pos);
            ofull <= 1'b1;
            if (vrdata != 7'd0) begin
              olast <= 1'b0; step <= 2'd1;
            end else begin
              olast <= 1'b1; state <= S_IDLE;
            end
          end else begin
            ow <= mk(mrrva_pkg::OUT_NOTE_ON, vsel, scan[6:0], vrdata, '0, '0,
                     iw.sample_pos);
            ofull <= 1'b1; olast <= 1'b1;
            vnote[vsel] <= {1'b0, scan[6:0]}; cur <= {1'b0, scan[6:0]};
            state <= S_IDLE;
          end
        end
        S_BEND: begin
          if (k == inuse) state <= S_IDLE;
          else if (ofree) begin
            ow <= mk(mrrva_pkg::OUT_BEND, k, '0, '0, iw.bend, '0, iw.sample_pos);
            ofull <= 1'b1; olast <= (k + 1'b1 == inuse); k <= k + 1'b1;
          end
        end
        S_POLY: begin
          if (poly_req == 4'(inuse) && k == '0 && !vdone) state <= S_IDLE;
          else if (VW'(poly_req) + k >= inuse) begin
            rpos_none <= 1'b1; cur <= 8'hFF; inuse <= VW'(poly_req);
            if (poly_req == 4'd1) begin
              scan <= '0; vaddr <= '0; vwdata <= '0; vwe <= 1'b1; state <= S_CLEAR;
            end else state <= S_IDLE;
            vdone <= 1'b0;
          end else if (ofree) begin
            vdone <= 1'b1; k <= k + 1'b1;
            if (!vnote[VW'(poly_req) + k][7]) begin
              ow <= mk(mrrva_pkg::OUT_NOTE_OFF, VW'(poly_req) + k,
                       vnote[VW'(poly_req) + k][6:0], '0, '0, '0, '0);
              ofull <= 1'b1; olast <= !later;
              vnote[VW'(poly_req) + k] <= 8'hFF;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !m_tvalid) else $error("input taken with output pending");
  a_chan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:2] >= 5'd1 && m_tdata[6:2] <= 5'd16))
    else $error("channel out of range");
  a_inuse: assert property (@(posedge clk) disable iff (rst)
    (inuse >= VW'(1)) && (inuse <= VW'(VOICES))) else $error("voice count bad");
`endif
endmodule
`default_nettype wire
